/* hw/rtl/sll_pkg.sv */
// ----------------------------------------------------------------------------
// sll_pkg
// Shared types and constants for the static linked list engine: operation
// and status codes, sequencer states and node store control.
// ----------------------------------------------------------------------------
package sll_pkg;

  localparam int CAPACITY_DEFAULT = 256;

  localparam int OP_W    = 3;
  localparam int POS_W   = 8;
  localparam int VAL_W   = 8;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_GET,
    OP_LOCATE,
    OP_PRIOR,
    OP_NEXT,
    OP_LENGTH,
    OP_CLEAR
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK,
    STAT_RANGE,
    STAT_NOT_FOUND,
    STAT_FULL
  } status_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_FREE,
    ST_WALK,
    ST_INS_JOIN,
    ST_DEL_HEAD,
    ST_DEL_JOIN,
    ST_DEL_FREE,
    ST_NXT_FETCH,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic link_we;
    logic value_we;
  } mem_ctl_t;

endpackage

/* hw/rtl/sll_if.sv */
// ----------------------------------------------------------------------------
// sll_if
// Valid/ready channels of the static linked list engine: request items in,
// result items out.
// ----------------------------------------------------------------------------
interface sll_req_if;
  logic                         valid;
  logic                         ready;
  logic [sll_pkg::OP_W-1:0]     operation;
  logic [sll_pkg::POS_W-1:0]    position;
  logic [sll_pkg::VAL_W-1:0]    value;

  modport source (output valid, operation, position, value, input ready);
  modport sink (input valid, operation, position, value, output ready);
endinterface

interface sll_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sll_pkg::STAT_W-1:0]   status;
  logic [sll_pkg::VAL_W-1:0]    result_value;
  logic [sll_pkg::COUNT_W-1:0]  result_count;

  modport source (output valid, status, result_value, result_count, input ready);
  modport sink (input valid, status, result_value, result_count, output ready);
endinterface

/* hw/rtl/sll_node_store.sv */
// ----------------------------------------------------------------------------
// sll_node_store
// Link and value memories with registered reads, plus the sweep that lays
// out the initial free chain after reset.
// ----------------------------------------------------------------------------
module sll_node_store #(
  parameter int CAPACITY = sll_pkg::CAPACITY_DEFAULT,
  localparam int NW = $clog2(CAPACITY)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sll_pkg::mem_ctl_t         ctl,
  input  logic [NW-1:0]             rd_addr,
  input  logic [NW-1:0]             link_waddr,
  input  logic [NW-1:0]             link_wdata,
  input  logic [NW-1:0]             value_waddr,
  input  logic [sll_pkg::VAL_W-1:0] value_wdata,
  output logic [NW-1:0]             link_q,
  output logic [sll_pkg::VAL_W-1:0] value_q,
  output logic                      busy
);

  logic [NW-1:0]             link_mem [CAPACITY];
  logic [sll_pkg::VAL_W-1:0] value_mem [CAPACITY];
  logic [NW-1:0]             sweep;
  logic [NW-1:0]             sweep_data;
  logic                      lw_en;
  logic [NW-1:0]             lw_addr;
  logic [NW-1:0]             lw_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b1;
      sweep <= '0;
    end else if (busy) begin
      sweep <= sweep + 1'b1;
      if (sweep == NW'(CAPACITY - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // free chain 1 -> 2 -> ... -> CAPACITY-2 -> none
  always_comb begin
    sweep_data = '0;
    if (sweep != '0 && sweep <= NW'(CAPACITY - 3)) begin
      sweep_data = sweep + 1'b1;
    end
    lw_en   = busy | ctl.link_we;
    lw_addr = busy ? sweep : link_waddr;
    lw_data = busy ? sweep_data : link_wdata;
  end

  always_ff @(posedge clk) begin
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
    if (ctl.value_we) begin
      value_mem[value_waddr] <= value_wdata;
    end
    if (ctl.rd_en) begin
      link_q  <= link_mem[rd_addr];
      value_q <= value_mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/sll_ctrl.sv */
// ----------------------------------------------------------------------------
// sll_ctrl
// Sequencer of the static linked list engine: decodes each request, walks
// the list one link per cycle through the node store, edits links and the
// free list, and holds the result item in an output register.
// ----------------------------------------------------------------------------
module sll_ctrl #(
  parameter int CAPACITY = sll_pkg::CAPACITY_DEFAULT,
  localparam int NW = $clog2(CAPACITY)
) (
  input  logic                      clk,
  input  logic                      rst,
  sll_req_if.sink                   request,
  sll_rsp_if.source                 response,
  output sll_pkg::mem_ctl_t         mc,
  output logic [NW-1:0]             rd_addr,
  output logic [NW-1:0]             link_waddr,
  output logic [NW-1:0]             link_wdata,
  output logic [NW-1:0]             value_waddr,
  output logic [sll_pkg::VAL_W-1:0] value_wdata,
  input  logic [NW-1:0]             link_q,
  input  logic [sll_pkg::VAL_W-1:0] value_q,
  input  logic                      store_busy
);

  localparam int CW = (NW > sll_pkg::COUNT_W) ? NW : sll_pkg::COUNT_W;

  sll_pkg::state_t              state, state_next;
  sll_pkg::op_t                 op, op_next;
  logic [sll_pkg::POS_W-1:0]    pos, pos_next;
  logic [sll_pkg::VAL_W-1:0]    val, val_next;
  logic [NW-1:0]                free_head, free_head_next;
  logic [NW-1:0]                list_head, list_head_next;
  logic [CW-1:0]                count, count_next;
  logic [NW-1:0]                cur, cur_next;
  logic [NW-1:0]                prev, prev_next;
  logic [sll_pkg::VAL_W-1:0]    prev_val, prev_val_next;
  logic [CW-1:0]                n, n_next;
  logic [sll_pkg::POS_W-1:0]    tgt, tgt_next;
  logic [NW-1:0]                jnode, jnode_next;
  sll_pkg::status_t             res_status, res_status_next;
  logic [sll_pkg::VAL_W-1:0]    res_value, res_value_next;
  logic [sll_pkg::COUNT_W-1:0]  res_count, res_count_next;
  logic                         out_valid, out_valid_next;
  sll_pkg::status_t             out_status, out_status_next;
  logic [sll_pkg::VAL_W-1:0]    out_value, out_value_next;
  logic [sll_pkg::COUNT_W-1:0]  out_count, out_count_next;
  logic [CW-1:0]                pos_w;
  logic                         positional;

  assign request.ready         = (state == sll_pkg::ST_IDLE);
  assign response.valid        = out_valid;
  assign response.status       = out_status;
  assign response.result_value = out_value;
  assign response.result_count = out_count;

  assign pos_w      = CW'(pos);
  assign positional = (op == sll_pkg::OP_INSERT) || (op == sll_pkg::OP_DELETE) ||
                      (op == sll_pkg::OP_GET);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sll_pkg::ST_INIT;
      free_head <= NW'(1);
      list_head <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      list_head <= list_head_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    pos        <= pos_next;
    val        <= val_next;
    cur        <= cur_next;
    prev       <= prev_next;
    prev_val   <= prev_val_next;
    n          <= n_next;
    tgt        <= tgt_next;
    jnode      <= jnode_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
    res_count  <= res_count_next;
    out_status <= out_status_next;
    out_value  <= out_value_next;
    out_count  <= out_count_next;
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    pos_next        = pos;
    val_next        = val;
    free_head_next  = free_head;
    list_head_next  = list_head;
    count_next      = count;
    cur_next        = cur;
    prev_next       = prev;
    prev_val_next   = prev_val;
    n_next          = n;
    tgt_next        = tgt;
    jnode_next      = jnode;
    res_status_next = res_status;
    res_value_next  = res_value;
    res_count_next  = res_count;
    out_valid_next  = out_valid;
    out_status_next = out_status;
    out_value_next  = out_value;
    out_count_next  = out_count;
    mc              = '0;
    rd_addr         = list_head;
    link_waddr      = cur;
    link_wdata      = free_head;
    value_waddr     = jnode;
    value_wdata     = val;

    if (out_valid && response.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      sll_pkg::ST_INIT: begin
        if (!store_busy) begin
          state_next = sll_pkg::ST_IDLE;
        end
      end

      sll_pkg::ST_IDLE: begin
        if (request.valid) begin
          op_next         = sll_pkg::op_t'(request.operation);
          pos_next        = request.position;
          val_next        = request.value;
          res_status_next = sll_pkg::STAT_OK;
          res_value_next  = '0;
          res_count_next  = '0;
          state_next      = sll_pkg::ST_DISPATCH;
        end
      end

      sll_pkg::ST_DISPATCH: begin
        cur_next      = list_head;
        prev_next     = '0;
        prev_val_next = '0;
        n_next        = CW'(1);
        tgt_next      = pos - 1'b1;
        state_next    = sll_pkg::ST_DONE;
        unique case (op)
          sll_pkg::OP_INSERT: begin
            if (pos == '0 || pos_w > count + 1'b1) begin
              res_status_next = sll_pkg::STAT_RANGE;
            end else if (free_head == '0) begin
              res_status_next = sll_pkg::STAT_FULL;
            end else begin
              mc.rd_en   = 1'b1;
              rd_addr    = free_head;
              jnode_next = free_head;
              state_next = sll_pkg::ST_INS_FREE;
            end
          end
          sll_pkg::OP_DELETE: begin
            if (pos == '0 || pos_w > count) begin
              res_status_next = sll_pkg::STAT_RANGE;
            end else begin
              mc.rd_en = 1'b1;
              if (pos == sll_pkg::POS_W'(1)) begin
                jnode_next = list_head;
                state_next = sll_pkg::ST_DEL_HEAD;
              end else begin
                state_next = sll_pkg::ST_WALK;
              end
            end
          end
          sll_pkg::OP_GET: begin
            if (pos == '0 || pos_w > count) begin
              res_status_next = sll_pkg::STAT_RANGE;
            end else begin
              mc.rd_en   = 1'b1;
              tgt_next   = pos;
              state_next = sll_pkg::ST_WALK;
            end
          end
          sll_pkg::OP_LOCATE, sll_pkg::OP_PRIOR, sll_pkg::OP_NEXT: begin
            if (list_head == '0) begin
              res_status_next = sll_pkg::STAT_NOT_FOUND;
            end else begin
              mc.rd_en   = 1'b1;
              state_next = sll_pkg::ST_WALK;
            end
          end
          sll_pkg::OP_LENGTH: begin
            res_count_next = count[sll_pkg::COUNT_W-1:0];
          end
          sll_pkg::OP_CLEAR: begin
            if (list_head == '0) begin
              count_next = '0;
            end else begin
              mc.rd_en   = 1'b1;
              state_next = sll_pkg::ST_CLEAR;
            end
          end
        endcase
      end

      sll_pkg::ST_INS_FREE: begin
        free_head_next = link_q;
        mc.value_we    = 1'b1;
        if (pos == sll_pkg::POS_W'(1)) begin
          mc.link_we     = 1'b1;
          link_waddr     = jnode;
          link_wdata     = list_head;
          list_head_next = jnode;
          count_next     = count + 1'b1;
          state_next     = sll_pkg::ST_DONE;
        end else begin
          mc.rd_en   = 1'b1;
          state_next = sll_pkg::ST_WALK;
        end
      end

      sll_pkg::ST_WALK: begin
        if (positional) begin
          if (n == CW'(tgt)) begin
            if (op == sll_pkg::OP_INSERT) begin
              mc.link_we = 1'b1;
              link_waddr = jnode;
              link_wdata = link_q;
              state_next = sll_pkg::ST_INS_JOIN;
            end else if (op == sll_pkg::OP_DELETE) begin
              mc.rd_en   = 1'b1;
              rd_addr    = link_q;
              jnode_next = link_q;
              state_next = sll_pkg::ST_DEL_JOIN;
            end else begin
              res_value_next = value_q;
              state_next     = sll_pkg::ST_DONE;
            end
          end else begin
            mc.rd_en = 1'b1;
            rd_addr  = link_q;
            cur_next = link_q;
            n_next   = n + 1'b1;
          end
        end else if (value_q == val) begin
          state_next = sll_pkg::ST_DONE;
          if (op == sll_pkg::OP_LOCATE) begin
            res_count_next = n[sll_pkg::COUNT_W-1:0];
          end else if (op == sll_pkg::OP_PRIOR) begin
            if (prev == '0) begin
              res_status_next = sll_pkg::STAT_NOT_FOUND;
            end else begin
              res_value_next = prev_val;
            end
          end else if (link_q == '0) begin
            res_status_next = sll_pkg::STAT_NOT_FOUND;
          end else begin
            mc.rd_en   = 1'b1;
            rd_addr    = link_q;
            state_next = sll_pkg::ST_NXT_FETCH;
          end
        end else if (link_q == '0) begin
          res_status_next = sll_pkg::STAT_NOT_FOUND;
          state_next      = sll_pkg::ST_DONE;
        end else begin
          mc.rd_en      = 1'b1;
          rd_addr       = link_q;
          prev_next     = cur;
          prev_val_next = value_q;
          cur_next      = link_q;
          n_next        = n + 1'b1;
        end
      end

      sll_pkg::ST_INS_JOIN: begin
        mc.link_we = 1'b1;
        link_wdata = jnode;
        count_next = count + 1'b1;
        state_next = sll_pkg::ST_DONE;
      end

      sll_pkg::ST_DEL_HEAD: begin
        list_head_next = link_q;
        state_next     = sll_pkg::ST_DEL_FREE;
      end

      sll_pkg::ST_DEL_JOIN: begin
        mc.link_we = 1'b1;
        link_wdata = link_q;
        state_next = sll_pkg::ST_DEL_FREE;
      end

      sll_pkg::ST_DEL_FREE: begin
        mc.link_we     = 1'b1;
        link_waddr     = jnode;
        free_head_next = jnode;
        count_next     = count - 1'b1;
        state_next     = sll_pkg::ST_DONE;
      end

      sll_pkg::ST_NXT_FETCH: begin
        res_value_next = value_q;
        state_next     = sll_pkg::ST_DONE;
      end

      sll_pkg::ST_CLEAR: begin
        mc.link_we     = 1'b1;
        free_head_next = cur;
        if (link_q != '0) begin
          mc.rd_en = 1'b1;
          rd_addr  = link_q;
          cur_next = link_q;
        end else begin
          list_head_next = '0;
          count_next     = '0;
          state_next     = sll_pkg::ST_DONE;
        end
      end

      sll_pkg::ST_DONE: begin
        if (!out_valid || response.ready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_value_next  = res_value;
          out_count_next  = res_count;
          state_next      = sll_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = sll_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/static_linked_list_engine.sv */
// ----------------------------------------------------------------------------
// static_linked_list_engine
// Ordered list of byte values held in a fixed node store with a free list.
//
// Channels: request (operation, position, value) and response (status,
// result_value, result_count), both valid/ready; an item moves when valid
// and ready are high at a rising edge. Every request item yields exactly one
// response item.
// Length and the range, full and empty-list rejects are answered without a
// read of the list; get, locate, prior and next walk it link by link; insert
// and delete walk to the position and then edit the links and the free list;
// clear visits every list node and returns it to the free list.
// One item is in work at a time; ready is high only while the sequencer is
// idle. A finished response sits in the output register, so the next
// request is accepted while it waits; a stalled receiver holds the
// sequencer only when a second response is ready to leave.
// Reset: rst is synchronous. After it, a sweep writes every link entry to lay
// out the free chain in the link memory; no request is accepted until it ends.
// ----------------------------------------------------------------------------
module static_linked_list_engine #(
  parameter int CAPACITY = sll_pkg::CAPACITY_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  sll_req_if.sink   request,
  sll_rsp_if.source response
);

  localparam int NW = $clog2(CAPACITY);

  sll_pkg::mem_ctl_t         mc;
  logic [NW-1:0]             rd_addr;
  logic [NW-1:0]             link_waddr;
  logic [NW-1:0]             link_wdata;
  logic [NW-1:0]             value_waddr;
  logic [sll_pkg::VAL_W-1:0] value_wdata;
  logic [NW-1:0]             link_q;
  logic [sll_pkg::VAL_W-1:0] value_q;
  logic                      store_busy;

  sll_node_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .ctl         (mc),
    .rd_addr     (rd_addr),
    .link_waddr  (link_waddr),
    .link_wdata  (link_wdata),
    .value_waddr (value_waddr),
    .value_wdata (value_wdata),
    .link_q      (link_q),
    .value_q     (value_q),
    .busy        (store_busy)
  );

  sll_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .request     (request),
    .response    (response),
    .mc          (mc),
    .rd_addr     (rd_addr),
    .link_waddr  (link_waddr),
    .link_wdata  (link_wdata),
    .value_waddr (value_waddr),
    .value_wdata (value_wdata),
    .link_q      (link_q),
    .value_q     (value_q),
    .store_busy  (store_busy)
  );

endmodule
